### sv/block_bitmap_allocator_assert.svh
// Assertion macros shared by the block bitmap allocator checker.
// Depends on nothing; every macro expands to one labeled concurrent assertion.
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("block bitmap allocator check failed");

// Consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("block bitmap allocator check failed");

`endif

### sv/bba_pkg.sv
// Types and constants of the block bitmap allocator.
// Used by the controller, the datapath, the top level and the checker.
package bba_pkg;

   localparam int MAX_BLOCKS     = 8192;
   localparam int BLK_BITS       = 13;
   localparam int TOTAL_BITS     = 14;
   localparam int CNT_BITS       = 14;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 14;

   // The map is kept as words of 32 bits; the scan evaluates one word a cycle.
   localparam int WORD_BITS      = 32;
   localparam int WORD_IDX_BITS  = $clog2(WORD_BITS);
   localparam int MAP_WORDS      = MAX_BLOCKS / WORD_BITS;
   localparam int WORD_ADDR_BITS = $clog2(MAP_WORDS);

   localparam logic [CNT_BITS-1:0]   CNT_MAX   = '1;
   localparam logic [TOTAL_BITS-1:0] TOP_LIMIT = TOTAL_BITS'(MAX_BLOCKS);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_DATA_BLOCK = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOTAL_BLOCKS     = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_FREE      = 2'd1,
      STATUS_RANGE        = 2'd2,
      STATUS_ALREADY_FREE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FREE_CHECK
   } state_type;

   typedef struct packed {
      logic       clear_step;
      logic       scan_start;
      logic       scan_step;
      logic       alloc_commit;
      logic       free_read;
      logic       free_commit;
      logic       rsp_load;
      status_type rsp_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic counter_zero;
      logic range_empty;
      logic free_in_range;
      logic hit;
      logic scan_end;
      logic bit_set;
   } dp_status_type;

endpackage

### sv/bba_ctrl.sv
// Controller of the block bitmap allocator: sequences clearing, scans and frees.
// Depends on bba_pkg; drives the datapath through ctl_cmd_type commands.
module bba_ctrl
   import bba_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_opcode,
   input  dp_status_type stat,
   output ctl_cmd_type   cmd,
   output logic          busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_opcode == OP_ALLOC) begin
                  if (stat.counter_zero || stat.range_empty) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_NO_FREE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end else begin
                  if (!stat.free_in_range) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_RANGE;
                  end else begin
                     cmd.free_read = 1'b1;
                     state_in      = ST_FREE_CHECK;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (stat.hit) begin
               cmd.alloc_commit = 1'b1;
               cmd.rsp_load     = 1'b1;
               cmd.rsp_status   = STATUS_OK;
               state_in         = ST_IDLE;
            end else if (stat.scan_end) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STATUS_NO_FREE;
               state_in       = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_FREE_CHECK: begin
            cmd.rsp_load = 1'b1;
            if (stat.bit_set) begin
               cmd.free_commit = 1'b1;
               cmd.rsp_status  = STATUS_OK;
            end else begin
               cmd.rsp_status = STATUS_ALREADY_FREE;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### sv/bba_datapath.sv
// Datapath of the block bitmap allocator: map memory, configuration, counter, result.
// Depends on bba_pkg; takes ctl_cmd_type commands and reports dp_status_type.
module bba_datapath
   import bba_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic [BLK_BITS-1:0]       req_block_number,
   input  ctl_cmd_type               cmd,
   output dp_status_type             stat,
   output logic                      rsp_strobe,
   output logic [1:0]                rsp_status,
   output logic [BLK_BITS-1:0]       rsp_granted_block,
   output logic [CNT_BITS-1:0]       rsp_free_count
);

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

   logic [BLK_BITS-1:0]       first_ff;
   logic [TOTAL_BITS-1:0]     total_ff;
   logic [CNT_BITS-1:0]       counter_ff;
   logic [CNT_BITS-1:0]       counter_in;
   logic [BLK_BITS-1:0]       blk_ff;
   logic [WORD_ADDR_BITS-1:0] scan_ptr_ff;
   logic [WORD_ADDR_BITS-1:0] eval_word_ff;
   logic [WORD_ADDR_BITS-1:0] clear_ptr_ff;
   logic [WORD_BITS-1:0]      rd_data_ff;
   logic                      rsp_strobe_ff;
   status_type                rsp_status_ff;
   logic [BLK_BITS-1:0]       rsp_granted_ff;
   logic [CNT_BITS-1:0]       rsp_free_count_ff;

   logic [BLK_BITS-1:0]       first_in;
   logic [TOTAL_BITS-1:0]     total_in;
   logic [TOTAL_BITS-1:0]     top_next;
   logic [TOTAL_BITS-1:0]     reload_value;
   logic [TOTAL_BITS-1:0]     top_cur;
   logic [TOTAL_BITS-1:0]     top_m1;
   logic [WORD_ADDR_BITS-1:0] first_word;
   logic [WORD_ADDR_BITS-1:0] last_word;
   logic [WORD_BITS-1:0]      lo_mask;
   logic [WORD_BITS-1:0]      hi_mask;
   logic [WORD_BITS-1:0]      cand;
   logic [WORD_IDX_BITS-1:0]  hit_idx;
   logic [BLK_BITS-1:0]       hit_block;

   logic                      rd_en;
   logic [WORD_ADDR_BITS-1:0] rd_addr;
   logic                      wr_en;
   logic [WORD_ADDR_BITS-1:0] wr_addr;
   logic [WORD_BITS-1:0]      wr_data;

   // Configuration: the counter reload sees the value being written this cycle.
   always_comb begin
      first_in = first_ff;
      total_in = total_ff;
      if (csr_write_enable && (csr_index == CSR_FIRST_DATA_BLOCK)) begin
         first_in = csr_write_data[BLK_BITS-1:0];
      end
      if (csr_write_enable && (csr_index == CSR_TOTAL_BLOCKS)) begin
         total_in = csr_write_data[TOTAL_BITS-1:0];
      end
      top_next     = (total_in > TOP_LIMIT) ? TOP_LIMIT : total_in;
      reload_value = (top_next > {1'b0, first_in}) ?
                     (top_next - {1'b0, first_in}) : '0;
   end

   always_comb begin
      if (csr_write_enable) begin
         counter_in = reload_value;
      end else if (cmd.alloc_commit) begin
         counter_in = counter_ff - CNT_BITS'(1);
      end else if (cmd.free_commit && (counter_ff != CNT_MAX)) begin
         counter_in = counter_ff + CNT_BITS'(1);
      end else begin
         counter_in = counter_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= '0;
         total_ff   <= TOP_LIMIT;
         counter_ff <= TOP_LIMIT;
      end else begin
         first_ff   <= first_in;
         total_ff   <= total_in;
         counter_ff <= counter_in;
      end
   end

   // Scan window: the first word is masked below the first data block and the
   // last word above the effective total.
   always_comb begin
      top_cur    = (total_ff > TOP_LIMIT) ? TOP_LIMIT : total_ff;
      top_m1     = top_cur - TOTAL_BITS'(1);
      first_word = first_ff[BLK_BITS-1:WORD_IDX_BITS];
      last_word  = top_m1[BLK_BITS-1:WORD_IDX_BITS];
      lo_mask    = (eval_word_ff == first_word) ?
                   ({WORD_BITS{1'b1}} << first_ff[WORD_IDX_BITS-1:0]) : '1;
      hi_mask    = (eval_word_ff == last_word) ?
                   ({WORD_BITS{1'b1}} >> (WORD_IDX_BITS'(WORD_BITS - 1) -
                                          top_m1[WORD_IDX_BITS-1:0])) : '1;
      cand       = ~rd_data_ff & lo_mask & hi_mask;
   end

   always_comb begin
      hit_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            hit_idx = WORD_IDX_BITS'(i);
         end
      end
      hit_block = {eval_word_ff, hit_idx};
   end

   // Memory port selection.
   always_comb begin
      rd_en   = cmd.scan_start || cmd.scan_step || cmd.free_read;
      rd_addr = scan_ptr_ff;
      if (cmd.scan_start) begin
         rd_addr = first_word;
      end else if (cmd.free_read) begin
         rd_addr = req_block_number[BLK_BITS-1:WORD_IDX_BITS];
      end
      wr_en   = cmd.clear_step || cmd.alloc_commit || cmd.free_commit;
      wr_addr = clear_ptr_ff;
      wr_data = '0;
      if (cmd.alloc_commit) begin
         wr_addr = eval_word_ff;
         wr_data = rd_data_ff | (WORD_BITS'(1) << hit_idx);
      end else if (cmd.free_commit) begin
         wr_addr = blk_ff[BLK_BITS-1:WORD_IDX_BITS];
         wr_data = rd_data_ff & ~(WORD_BITS'(1) << blk_ff[WORD_IDX_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         eval_word_ff <= rd_addr;
      end
      if (cmd.scan_start) begin
         scan_ptr_ff <= first_word + WORD_ADDR_BITS'(1);
      end else if (cmd.scan_step) begin
         scan_ptr_ff <= scan_ptr_ff + WORD_ADDR_BITS'(1);
      end
      if (cmd.free_read) begin
         blk_ff <= req_block_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ptr_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_ptr_ff <= clear_ptr_ff + WORD_ADDR_BITS'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_load;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff     <= cmd.rsp_status;
         rsp_granted_ff    <= cmd.alloc_commit ? hit_block : '0;
         rsp_free_count_ff <= counter_in;
      end
   end

   always_comb begin
      stat.clear_done    = (clear_ptr_ff == '1);
      stat.counter_zero  = (counter_ff == '0);
      stat.range_empty   = !(top_cur > {1'b0, first_ff});
      stat.free_in_range = (req_block_number >= first_ff) &&
                           ({1'b0, req_block_number} < top_cur);
      stat.hit           = (cand != '0);
      stat.scan_end      = (eval_word_ff == last_word);
      stat.bit_set       = rd_data_ff[blk_ff[WORD_IDX_BITS-1:0]];
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_block = rsp_granted_ff;
   assign rsp_free_count    = rsp_free_count_ff;

endmodule

### sv/block_bitmap_allocator.sv
// Top level of the block bitmap allocator: first-fit block allocation over a usage map.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
//
//   channel    handshake                 payload
//   request    start, busy               req_opcode, req_block_number
//   result     rsp_strobe (one cycle)    rsp_status, rsp_granted_block, rsp_free_count
//   registers  csr_write_enable          csr_index, csr_write_data
//
// After reset is released the map is cleared one 32-bit word a cycle, all 256 words,
// with busy high. An allocate scans one map word a cycle, with busy high, from the first
// data block's word to the word with the first free block or, if none, the last word
// (up to 256 words). A free keeps busy high while the word read at the accepting edge is
// checked and written back. A request rejected at once never raises busy. Otherwise the
// result strobe rises at the edge where busy falls; the receiver cannot stall it.
module block_bitmap_allocator
   import bba_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_opcode,
   input  logic [BLK_BITS-1:0]       req_block_number,
   output logic                      rsp_strobe,
   output logic [1:0]                rsp_status,
   output logic [BLK_BITS-1:0]       rsp_granted_block,
   output logic [CNT_BITS-1:0]       rsp_free_count,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   ctl_cmd_type   cmd;
   dp_status_type stat;

   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   bba_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_block_number  (req_block_number),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_granted_block (rsp_granted_block),
      .rsp_free_count    (rsp_free_count)
   );

endmodule

### sv/bba_checker.sv
// Port-level checker for the block bitmap allocator, bound to the top level.
// Depends on bba_pkg and the macros in block_bitmap_allocator_assert.svh.
`include "block_bitmap_allocator_assert.svh"

module bba_checker
   import bba_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_strobe,
   input logic [1:0]          rsp_status,
   input logic [BLK_BITS-1:0] rsp_granted_block
);

   // The map clear keeps the block busy right after reset.
   `BBA_ASSERT_SAME(a_busy_after_reset, clock, reset, $past(reset), busy)

   // A result is only shown once the block has gone back to idle.
   `BBA_ASSERT_SAME(a_strobe_when_idle, clock, reset, rsp_strobe, !busy)

   // Without an accepted transaction or work in progress no result can follow.
   `BBA_ASSERT_NEXT(a_no_spurious_result, clock, reset, !busy && !start, !rsp_strobe)

   // Only a successful allocate grants a nonzero block.
   `BBA_ASSERT_SAME(a_failed_grants_zero, clock, reset,
      rsp_strobe && (rsp_status != STATUS_OK), rsp_granted_block == '0)

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_granted_block (rsp_granted_block)
);
